// ===== sv/indexed_min_heap_unit_macros.svh =====
// Assertion macros shared by the heap unit checker.
// No dependencies.
`ifndef INDEXED_MIN_HEAP_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define IMH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/imh_pkg.sv =====
// Shared parameters and codes for the indexed min-heap unit.
// No dependencies.
package imh_pkg;
  localparam int CAPACITY = 256;
  localparam int ID_COUNT = 1024;
  localparam int KEY_BITS = 32;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;
endpackage

// ===== sv/indexed_min_heap_unit.sv =====
// Indexed binary min-heap: heap and position stores in synchronous RAMs.
// Depends on imh_pkg.
//
// channel | dir | fields
// in_     | in  | tdata: func, item_id, item_key, slot
// out_    | out | tdata: status, removed_id, removed_key, id_slot, entry_count
//
// One item at a time. Insert sifts the new entry up; remove moves the last
// entry into the freed slot and sifts it down, then up. Both walks are paced
// by the single-port heap RAM read. After reset a clearing pass zeroes the
// position store; no item is taken meanwhile. A stalled result holds in the
// output register, and the next item waits until it is taken.
module indexed_min_heap_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[0], item_id[10:1], item_key[42:11], slot[51:43], zero fill to 56
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], removed_id[11:2], removed_key[43:12], id_slot[52:44],
  // entry_count[61:53], zero fill to 64
  output logic [63:0] out_tdata
);
  localparam int CAPACITY = imh_pkg::CAPACITY;
  localparam int ID_COUNT = imh_pkg::ID_COUNT;
  localparam int KEY_BITS = imh_pkg::KEY_BITS;
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY + 1);
  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int PW = IW;

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_RDP  = 11'b00000000100,  // issue read
    S_WT   = 11'b00000001000,  // data back
    S_UPC  = 11'b00000010000,  // sift-up compare parent
    S_RDL  = 11'b00000100000,  // sift-down read left
    S_RDR  = 11'b00001000000,  // read right
    S_DNC  = 11'b00010000000,  // down compare
    S_SWP  = 11'b00100000000,  // write second half of swap
    S_POS  = 11'b01000000000,  // read id slot
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  // heap memory (entries 1..CAPACITY)
  logic [9:0]          hid_mem [CAPACITY+1];
  logic [KEY_BITS-1:0] hkey_mem [CAPACITY+1];
  logic [SW-1:0]       pos_mem [ID_COUNT];

  logic [AW-1:0] h_addr; logic h_we; logic [9:0] h_wid; logic [KEY_BITS-1:0] h_wkey;
  logic [9:0] h_rid; logic [KEY_BITS-1:0] h_rkey;
  logic [IW-1:0] p_addr; logic p_we; logic [SW-1:0] p_wd; logic [SW-1:0] p_rd;

  always_ff @(posedge clk) begin
    if (h_we) begin
      hid_mem[h_addr]  <= h_wid;
      hkey_mem[h_addr] <= h_wkey;
    end
    h_rid  <= hid_mem[h_addr];
    h_rkey <= hkey_mem[h_addr];
  end
  always_ff @(posedge clk) begin
    if (p_we) pos_mem[p_addr] <= p_wd;
    p_rd <= pos_mem[p_addr];
  end

  logic [SW-1:0] cnt_r, cnt_nxt, cur_r, cur_nxt, tgt_r, tgt_nxt;
  logic [PW:0] clr_r, clr_nxt;
  logic func_r, func_nxt, phase_r, phase_nxt; // phase: moving entry has swapped
  logic [1:0] sub_r, sub_nxt;
  // rid: id of the entry last swapped with the moving one
  logic [9:0] id_r, id_nxt, cid_r, cid_nxt, lid_r, lid_nxt, rid_r, rid_nxt;
  logic [KEY_BITS-1:0] ckey_r, ckey_nxt, lkey_r, lkey_nxt;
  logic [9:0] oid_r, oid_nxt; logic [31:0] okey_r, okey_nxt;
  logic [1:0] st_r, st_nxt;
  logic [SW-1:0] oslot_r, oslot_nxt;
  logic ov_r, ov_nxt;
  logic skip_pos;

  logic in_func; logic [9:0] in_id; logic [KEY_BITS-1:0] in_key; logic [8:0] in_slot;
  assign in_func = in_tdata[0];
  assign in_id   = in_tdata[10:1];
  assign in_key  = KEY_BITS'(in_tdata[42:11]);
  assign in_slot = in_tdata[51:43];

  assign in_tready  = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;

  function automatic logic id_ok(logic [9:0] i);
    return {22'd0, i} < 32'(ID_COUNT);
  endfunction

  logic [SW:0] lc, rc;
  assign lc = {cur_r, 1'b0};
  assign rc = {cur_r, 1'b1};

  // remove: the last swap partner shares the moving id, so its slot stands
  assign skip_pos = (func_r == imh_pkg::FUNC_REMOVE) && phase_r && (rid_r == cid_r);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; cur_nxt = cur_r; tgt_nxt = tgt_r;
    clr_nxt = clr_r; func_nxt = func_r; phase_nxt = phase_r; sub_nxt = sub_r;
    id_nxt = id_r; cid_nxt = cid_r; lid_nxt = lid_r; rid_nxt = rid_r;
    ckey_nxt = ckey_r; lkey_nxt = lkey_r;
    oid_nxt = oid_r; okey_nxt = okey_r; st_nxt = st_r; oslot_nxt = oslot_r;
    ov_nxt = ov_r;
    h_addr = cur_r[AW-1:0]; h_we = 1'b0; h_wid = cid_r; h_wkey = ckey_r;
    p_addr = id_r[IW-1:0]; p_we = 1'b0; p_wd = cur_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        p_addr = clr_r[IW-1:0]; p_we = 1'b1; p_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (PW+1)'(ID_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          func_nxt = in_func; id_nxt = in_id; phase_nxt = 1'b0;
          oid_nxt = '0; okey_nxt = '0; st_nxt = imh_pkg::ST_OK;
          if (in_func == imh_pkg::FUNC_INSERT) begin
            if (cnt_r == SW'(CAPACITY)) begin
              st_nxt = imh_pkg::ST_FULL; state_nxt = S_POS;
            end else begin
              cnt_nxt = cnt_r + 1'b1; cur_nxt = cnt_r + 1'b1;
              cid_nxt = in_id; ckey_nxt = in_key;
              state_nxt = S_UPC;
            end
          end else if (in_slot == 9'd0 || SW'(in_slot) > cnt_r ||
                       {23'd0, in_slot} > 32'(CAPACITY)) begin
            st_nxt = imh_pkg::ST_BAD_SLOT; state_nxt = S_POS;
          end else begin
            tgt_nxt = SW'(in_slot); cur_nxt = cnt_r;
            sub_nxt = 2'd0; state_nxt = S_RDP;
            h_addr = AW'(in_slot);
          end
        end
      end
      S_RDP: begin
        // remove: sub 0 fetched target, read last next
        if (sub_r == 2'd0) begin
          h_addr = cnt_r[AW-1:0]; sub_nxt = 2'd1; state_nxt = S_WT;
          oid_nxt = h_rid; okey_nxt = 32'(h_rkey);
        end
      end
      S_WT: begin
        if (sub_r == 2'd1) begin
          // h_rid/h_rkey = last entry; clear removed pos
          p_addr = oid_r[IW-1:0]; p_wd = '0; p_we = id_ok(oid_r);
          cid_nxt = h_rid; ckey_nxt = h_rkey;
          cnt_nxt = cnt_r - 1'b1;
          if (tgt_r == cnt_r) state_nxt = S_POS;
          else begin
            cur_nxt = tgt_r; sub_nxt = 2'd2;
          end
        end else begin
          // place moving entry at cur
          h_addr = cur_r[AW-1:0]; h_we = 1'b1;
          p_addr = cid_r[IW-1:0]; p_wd = cur_r; p_we = id_ok(cid_r);
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        if (rc <= {1'b0, cnt_r}) begin
          h_addr = AW'(lc); state_nxt = S_RDR;
        end else if (lc <= {1'b0, cnt_r}) begin
          h_addr = AW'(lc); state_nxt = S_RDR; sub_nxt = 2'd3;
        end else begin
          state_nxt = S_UPC;
        end
        if (state_nxt == S_RDR && sub_nxt != 2'd3) sub_nxt = 2'd2;
      end
      S_RDR: begin
        h_addr = AW'(rc);
        lid_nxt = h_rid; lkey_nxt = h_rkey; state_nxt = S_DNC;
      end
      S_DNC: begin
        // pick child; sub 3 = left only
        logic pick_l;
        logic [9:0] bid; logic [KEY_BITS-1:0] bkey; logic [SW-1:0] bslot;
        pick_l = (sub_r == 2'd3) || (lkey_r < h_rkey);
        bid = pick_l ? lid_r : h_rid; bkey = pick_l ? lkey_r : h_rkey;
        bslot = pick_l ? SW'(lc) : SW'(rc);
        if (bkey < ckey_r) begin
          // moving entry's slot first, child's slot in the next cycle
          h_addr = cur_r[AW-1:0]; h_we = 1'b1; h_wid = bid; h_wkey = bkey;
          p_addr = cid_r[IW-1:0]; p_wd = bslot; p_we = id_ok(cid_r);
          rid_nxt = bid; phase_nxt = 1'b1;
          cur_nxt = bslot; state_nxt = S_SWP; sub_nxt = 2'd2;
        end else begin
          state_nxt = S_UPC;
        end
      end
      S_SWP: begin
        h_addr = cur_r[AW-1:0]; h_we = 1'b1;
        p_addr = rid_r[IW-1:0]; p_wd = cur_r >> 1; p_we = id_ok(rid_r);
        state_nxt = S_RDL;
      end
      S_UPC: begin
        // sub 0: issue parent read; sub 1: compare
        if (sub_r != 2'd1) begin
          if (cur_r == SW'(1)) begin
            h_addr = cur_r[AW-1:0]; h_we = 1'b1;
            p_addr = cid_r[IW-1:0]; p_wd = cur_r; p_we = id_ok(cid_r) && !skip_pos;
            state_nxt = S_POS;
          end else begin
            h_addr = AW'(cur_r >> 1); sub_nxt = 2'd1;
          end
        end else begin
          if (h_rkey > ckey_r) begin
            h_addr = cur_r[AW-1:0]; h_we = 1'b1; h_wid = h_rid; h_wkey = h_rkey;
            p_addr = h_rid[IW-1:0]; p_wd = cur_r; p_we = id_ok(h_rid);
            rid_nxt = h_rid; phase_nxt = 1'b1;
            cur_nxt = cur_r >> 1;
          end else begin
            h_addr = cur_r[AW-1:0]; h_we = 1'b1;
            p_addr = cid_r[IW-1:0]; p_wd = cur_r; p_we = id_ok(cid_r) && !skip_pos;
            state_nxt = S_POS;
          end
          sub_nxt = 2'd0;
        end
      end
      S_POS: begin
        p_addr = id_r[IW-1:0]; state_nxt = S_OUT;
      end
      S_OUT: begin
        oslot_nxt = id_ok(id_r) ? p_rd : '0;
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_IDLE && state_nxt == S_UPC) sub_nxt = 2'd0;
    if (state_r != S_UPC && state_nxt == S_UPC) sub_nxt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; cnt_r <= '0; clr_r <= '0; ov_r <= 1'b0; sub_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
      sub_r <= sub_nxt;
    end
  end
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; tgt_r <= tgt_nxt; func_r <= func_nxt; phase_r <= phase_nxt;
    id_r <= id_nxt; cid_r <= cid_nxt; lid_r <= lid_nxt; rid_r <= rid_nxt;
    ckey_r <= ckey_nxt; lkey_r <= lkey_nxt;
    oid_r <= oid_nxt; okey_r <= okey_nxt; st_r <= st_nxt; oslot_r <= oslot_nxt;
  end

  assign out_tdata = {2'd0, 9'(cnt_r), 9'(oslot_r), okey_r, oid_r, st_r};
endmodule

// ===== sv/imh_checker.sv =====
// Port-level checks for the indexed min-heap unit, bound to the top level.
// Depends on indexed_min_heap_unit_macros.svh.
`include "indexed_min_heap_unit_macros.svh"
module imh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  `IMH_ASSERT_IMPL(a_no_take_while_full, clk, rst_n, out_tvalid, !in_tready, "item taken while result pending")
  `IMH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `IMH_ASSERT_IMPL(a_status_code, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'd3, "bad status code")
  `IMH_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready right after item")
endmodule

bind indexed_min_heap_unit imh_checker u_imh_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== tb/sv/testbench.sv =====
// Testbench for indexed_min_heap_unit: directed rows, fill to capacity, random insert/remove.
// Depends on imh_pkg and the RTL; results checked against an in-bench heap predictor.
`timescale 1ns / 100ps
module testbench;

  localparam int CAP = 256;
  localparam int IDS = 1024;
  localparam int N_RANDOM = 1480;

  typedef struct packed {
    logic       func;
    logic [9:0] item_id;
    logic [31:0] item_key;
    logic [8:0] slot;
  } heap_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  removed_id;
    logic [31:0] removed_key;
    logic [8:0]  id_slot;
    logic [8:0]  entry_count;
  } heap_resp_t;

  typedef struct {
    heap_req_t req;
    logic      has_fixed;
    heap_resp_t fixed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  indexed_min_heap_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [9:0]  hp_id [1:CAP];
  logic [31:0] hp_key[1:CAP];
  logic [8:0]  pos_of[0:IDS-1];
  int          fill;

  heap_resp_t expected_q[$];
  int  fail_cnt = 0;
  bit  stim_done = 0;
  bit  long_hold = 0;

  function automatic void put_entry(int s, logic [9:0] id, logic [31:0] k);
    hp_id[s] = id;
    hp_key[s] = k;
    pos_of[id] = s[8:0];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [9:0] ia;
    logic [31:0] ka;
    ia = hp_id[a];
    ka = hp_key[a];
    put_entry(a, hp_id[b], hp_key[b]);
    put_entry(b, ia, ka);
  endfunction

  function automatic heap_resp_t heap_apply(heap_req_t r);
    heap_resp_t o;
    int cur, lst, l, c;
    o = '0;
    if (r.func == imh_pkg::FUNC_INSERT) begin
      if (fill >= CAP) begin
        o.status = imh_pkg::ST_FULL;
      end else begin
        fill++;
        cur = fill;
        while (cur != 1 && hp_key[cur/2] > r.item_key) begin
          put_entry(cur, hp_id[cur/2], hp_key[cur/2]);
          cur /= 2;
        end
        put_entry(cur, r.item_id, r.item_key);
      end
    end else if (r.slot == 0 || r.slot > fill) begin
      o.status = imh_pkg::ST_BAD_SLOT;
    end else begin
      lst = fill;
      o.status = imh_pkg::ST_OK;
      o.removed_id = hp_id[r.slot];
      o.removed_key = hp_key[r.slot];
      pos_of[o.removed_id] = '0;
      fill--;
      if (r.slot != lst) begin
        cur = r.slot;
        put_entry(cur, hp_id[lst], hp_key[lst]);
        forever begin
          l = cur * 2;
          if (l + 1 <= fill) c = (hp_key[l] < hp_key[l+1]) ? l : l + 1;
          else if (l <= fill) c = l;
          else break;
          if (hp_key[c] < hp_key[cur]) begin
            swap_entries(c, cur);
            cur = c;
          end else break;
        end
        while (cur != 1 && hp_key[cur/2] > hp_key[cur]) begin
          swap_entries(cur/2, cur);
          cur /= 2;
        end
      end
    end
    o.id_slot = pos_of[r.item_id];
    o.entry_count = fill[8:0];
    return o;
  endfunction

  function automatic logic [55:0] pack_req(heap_req_t r);
    return {4'b0, r.slot, r.item_key, r.item_id, r.func};
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(heap_req_t r);
    in_tvalid <= 1'b1;
    in_tdata <= pack_req(r);
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(heap_apply(r));
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic heap_req_t rand_item();
    heap_req_t r;
    int p;
    p = $urandom_range(0, 99);
    r.func = (p < 55) ? imh_pkg::FUNC_INSERT : imh_pkg::FUNC_REMOVE;
    r.item_id = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 3) == 0) r.item_key = $urandom_range(0, 15);
    else r.item_key = $urandom();
    p = $urandom_range(0, 99);
    if (p < 80 && fill > 0) r.slot = 9'($urandom_range(1, fill));
    else if (p < 90) r.slot = 9'($urandom_range(0, 511));
    else r.slot = fill[8:0];
    // half the time, query an id taken from the heap
    if (fill > 0 && $urandom_range(0, 1)) r.item_id = hp_id[$urandom_range(1, fill)];
    return r;
  endfunction

  // stimulus
  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    heap_req_t r;
    int n;
    for (int i = 0; i < IDS; i++) pos_of[i] = '0;
    fill = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed table
    row.has_fixed = 1'b1;
    row.req = '{imh_pkg::FUNC_REMOVE, 10'd0, 32'd0, 9'd1};
    row.fixed = '{imh_pkg::ST_BAD_SLOT, 10'd0, 32'd0, 9'd0, 9'd0};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_INSERT, 10'd1023, 32'hFFFF_FFFF, 9'd0};
    row.fixed = '{imh_pkg::ST_OK, 10'd0, 32'd0, 9'd1, 9'd1};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_REMOVE, 10'd1023, 32'd0, 9'd0};
    row.fixed = '{imh_pkg::ST_BAD_SLOT, 10'd0, 32'd0, 9'd1, 9'd1};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_REMOVE, 10'd1023, 32'd0, 9'd511};
    row.fixed = '{imh_pkg::ST_BAD_SLOT, 10'd0, 32'd0, 9'd1, 9'd1};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_INSERT, 10'd0, 32'd0, 9'd511};
    row.fixed = '{imh_pkg::ST_OK, 10'd0, 32'd0, 9'd1, 9'd2};  rows.push_back(row);
    row.has_fixed = 1'b0;
    row.req = '{imh_pkg::FUNC_INSERT, 10'd5, 32'd7, 9'd0};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_INSERT, 10'd6, 32'd7, 9'd0};  rows.push_back(row); // equal keys
    row.req = '{imh_pkg::FUNC_INSERT, 10'd5, 32'd3, 9'd0};  rows.push_back(row); // duplicate id
    row.req = '{imh_pkg::FUNC_INSERT, 10'd9, 32'd7, 9'd0};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_REMOVE, 10'd5, 32'd0, 9'd1};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_REMOVE, 10'd6, 32'd0, 9'd2};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_REMOVE, 10'd1023, 32'd0, 9'd4};  rows.push_back(row); // last slot
    row.req = '{imh_pkg::FUNC_REMOVE, 10'd9, 32'd0, 9'd1};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_INSERT, 10'h2AA, 32'hAAAA_AAAA, 9'd0};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_INSERT, 10'h155, 32'h5555_5555, 9'd0};  rows.push_back(row);
    row.req = '{imh_pkg::FUNC_REMOVE, 10'h155, 32'd0, 9'd2};  rows.push_back(row);
    foreach (rows[i]) begin
      send_item(rows[i].req);
      if (rows[i].has_fixed && expected_q[$] != rows[i].fixed) begin
        $error("directed row %0d: table %h predictor %h", i, rows[i].fixed, expected_q[$]);
        fail_cnt++;
      end
      idle_gap();
    end
    // fill to capacity and overflow, with the receiver held off for a while
    long_hold = 1'b1;
    while (fill < CAP) begin
      r = '{imh_pkg::FUNC_INSERT, 10'($urandom_range(0, 1023)), $urandom_range(0, 300), 9'd0};
      send_item(r);
    end
    long_hold = 1'b0;
    r = '{imh_pkg::FUNC_INSERT, 10'd77, 32'd0, 9'd0};
    send_item(r);
    r = '{imh_pkg::FUNC_REMOVE, 10'd77, 32'd0, 9'd257};
    send_item(r);
    // drain partly via random removes, then random mix
    n = 0;
    while (n < N_RANDOM) begin
      r = rand_item();
      if (n < 200) r.func = imh_pkg::FUNC_REMOVE;
      send_item(r);
      idle_gap();
      n++;
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver
  initial begin
    int g;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      // one long hold-off while the sender keeps offering items
      if (long_hold && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // checker
  always @(posedge clk) begin
    heap_resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status      = out_tdata[1:0];
      got.removed_id  = out_tdata[11:2];
      got.removed_key = out_tdata[43:12];
      got.id_slot     = out_tdata[52:44];
      got.entry_count = out_tdata[61:53];
      if (expected_q.size() == 0) begin
        $error("result with no item pending: %h", got);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status); fail_cnt++;
        end
        if (got.removed_id != want.removed_id) begin
          $error("removed_id: expected %0d actual %0d", want.removed_id, got.removed_id);
          fail_cnt++;
        end
        if (got.removed_key != want.removed_key) begin
          $error("removed_key: expected %h actual %h", want.removed_key, got.removed_key);
          fail_cnt++;
        end
        if (got.id_slot != want.id_slot) begin
          $error("id_slot: expected %0d actual %0d", want.id_slot, got.id_slot); fail_cnt++;
        end
        if (got.entry_count != want.entry_count) begin
          $error("entry_count: expected %0d actual %0d", want.entry_count, got.entry_count);
          fail_cnt++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== indexed_min_heap_unit.f =====
+incdir+sv
sv/imh_pkg.sv
sv/indexed_min_heap_unit.sv
sv/imh_checker.sv
tb/sv/testbench.sv
